[rtl/krt_pkg.sv]
// ----------------------------------------------------------------------------
// krt_pkg - shared definitions for the keyed record table
// Record layout, operation and status codes, sequencer states and the
// key folding and blank key helpers.
// ----------------------------------------------------------------------------
package krt_pkg;

	localparam int CAPACITY  = 64;
	localparam int AW        = $clog2(CAPACITY);
	localparam int CW        = $clog2(CAPACITY + 1);
	localparam int KEY_BYTES = 8;
	localparam int MAX_OUT   = 64;
	localparam int KW        = $clog2(MAX_OUT + 1);
	localparam int VALUE_W   = 54;
	localparam int PROD_W    = 48;
	localparam logic [15:0] THR_RESET = 16'd5;
	localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};

	typedef struct packed {
		logic [63:0] key;
		logic [31:0] price;
		logic [15:0] stock;
	} rec_t;

	localparam int REC_W = $bits(rec_t);

	typedef enum logic [2:0] {
		OP_INSERT    = 3'd0,
		OP_FIND      = 3'd1,
		OP_SET_STOCK = 3'd2,
		OP_REMOVE    = 3'd3,
		OP_SORT      = 3'd4,
		OP_TOTAL     = 3'd5,
		OP_LIST_ALL  = 3'd6,
		OP_LIST_LOW  = 3'd7
	} op_t;

	typedef enum logic [2:0] {
		STAT_OK       = 3'd0,
		STAT_FULL     = 3'd1,
		STAT_DUP      = 3'd2,
		STAT_NOTFOUND = 3'd3,
		STAT_EMPTY    = 3'd4,
		STAT_INVALID  = 3'd5
	} stat_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_INS, ST_LK_RD, ST_LK_CHK, ST_SET, ST_SH_RD, ST_SH_WR,
		ST_SO_START, ST_SO_LD, ST_SO_RD, ST_SO_CMP,
		ST_TO_RD, ST_TO_LD, ST_TO_MUL, ST_TO_ACC,
		ST_LI_RD, ST_LI_LD, ST_LI_CHK, ST_LI_PUT, ST_LI_FIN,
		ST_PROD, ST_EMIT_REC, ST_EMIT_ST
	} state_t;

	// upper-case a..z in the counted bytes, clear the rest
	function automatic logic [63:0] fold_key(input logic [63:0] raw);
		logic [63:0] res;
		logic [7:0]  b;
		res = '0;
		for (int i = 0; i < 8; i++) begin
			b = raw[8*i +: 8];
			if (b inside {[8'h61:8'h7A]})
				b = b - 8'h20;
			if (i < KEY_BYTES)
				res[8*i +: 8] = b;
		end
		return res;
	endfunction

	// key made only of NUL and whitespace bytes
	function automatic logic key_blank(input logic [63:0] key);
		logic blank;
		logic [7:0] b;
		blank = 1'b1;
		for (int i = 0; i < 8; i++) begin
			b = key[8*i +: 8];
			if (i < KEY_BYTES && !(b inside {8'h00, 8'h20, [8'h09:8'h0D]}))
				blank = 1'b0;
		end
		return blank;
	endfunction

endpackage

[rtl/krt_if.sv]
// ----------------------------------------------------------------------------
// krt_cmd_if / krt_rsp_if - command and response channels
// Valid/ready channels; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface krt_cmd_if;
	logic        valid;
	logic        ready;
	logic [2:0]  op;
	logic [63:0] key_code;
	logic [31:0] price;
	logic [15:0] stock_count;
	logic        sort_descending;

	modport source (output valid, op, key_code, price, stock_count, sort_descending,
		input ready);
	modport sink (input valid, op, key_code, price, stock_count, sort_descending,
		output ready);
endinterface

interface krt_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [63:0] out_key;
	logic [31:0] out_price;
	logic [15:0] out_stock;
	logic [53:0] out_value;
	logic [6:0]  record_count;
	logic        last_result;

	modport source (output valid, status, out_key, out_price, out_stock, out_value,
		record_count, last_result, input ready);
	modport sink (input valid, status, out_key, out_price, out_stock, out_value,
		record_count, last_result, output ready);
endinterface

[rtl/keyed_record_table_core.sv]
// ----------------------------------------------------------------------------
// keyed_record_table_core - packed record table with keyed commands
// Insert, find, set stock, remove, sort, total and list over a table of
// records held in one RAM, walked by a small sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   cmd carries one command word; it is taken only while the sequencer idles,
//   so cmd.ready is low from acceptance until the last response word has been
//   loaded into the output register. rsp carries response words; list
//   commands give one word per listed record (at most 64), the final one flagged.
//   cfg_we/cfg_wdata write the low stock threshold (reset 5); write it only
//   while no command is in progress.
// Sequencing:
//   insert/find/set/remove: lookup walks the RAM one record at a time;
//   remove then shifts each following record down one place before responding.
//   total and list read each record in turn.
//   sort: bubble passes over the single read port.
//   All walks share the one RAM read port; products come from the shared 32x16 multiplier.
// Reset clears the record count and sets the threshold to 5; no clearing pass is needed.
// A stalled rsp holds its word; the sequencer waits for the register to free.
// ----------------------------------------------------------------------------
module keyed_record_table_core (
	input  logic        clk,
	input  logic        arst_n,
	krt_cmd_if.sink     cmd,
	krt_rsp_if.source   rsp,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata
);

	krt_pkg::state_t state_q, state_d;
	logic [krt_pkg::CW-1:0]      cnt_q;
	logic [krt_pkg::CW-1:0]      idx_q;
	logic [krt_pkg::CW-1:0]      lim_q;
	logic [krt_pkg::KW-1:0]      kcnt_q;
	logic [15:0]                 thr_q;
	logic                        pend_q;
	logic                        rsp_valid_q;
	krt_pkg::op_t                op_q;
	krt_pkg::stat_t              status_q;
	krt_pkg::stat_t              acc_status;
	logic [63:0]                 key_q;
	logic [31:0]                 price_q;
	logic [15:0]                 stock_q;
	logic                        desc_q;
	krt_pkg::rec_t               rec_q, cur_q, pend_rec_q;
	logic [krt_pkg::PROD_W-1:0]  prod_q, pend_prod_q;
	logic [krt_pkg::VALUE_W-1:0] sum_q;
	logic [krt_pkg::VALUE_W:0]   sum_add;
	logic [63:0]                 folded;
	logic [krt_pkg::CW-1:0]      idx_nxt;
	logic                        out_free;
	logic                        lk_hit;
	logic                        swap;
	logic                        match;

	// RAM port controls
	logic                        ram_we;
	logic [krt_pkg::AW-1:0]      ram_waddr, ram_raddr;
	krt_pkg::rec_t               ram_wrec, rd_rec;
	logic [krt_pkg::REC_W-1:0]   ram_rdata;

	krt_ram #(.WIDTH(krt_pkg::REC_W), .DEPTH(krt_pkg::CAPACITY)) u_ram (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (ram_wrec),
		.rd_addr (ram_raddr),
		.rd_data (ram_rdata)
	);

	assign rd_rec    = krt_pkg::rec_t'(ram_rdata);
	assign folded    = krt_pkg::fold_key(cmd.key_code);
	assign idx_nxt   = idx_q + 1'b1;
	assign out_free  = !rsp_valid_q || rsp.ready;
	assign lk_hit    = rd_rec.key == key_q;
	assign swap      = desc_q ? (cur_q.stock < rd_rec.stock) : (cur_q.stock > rd_rec.stock);
	assign match     = (op_q == krt_pkg::OP_LIST_ALL) || (rec_q.stock < thr_q);
	assign sum_add   = {1'b0, sum_q} + (krt_pkg::VALUE_W + 1)'(prod_q);
	assign cmd.ready = state_q == krt_pkg::ST_IDLE;
	assign rsp.valid = rsp_valid_q;

	// status decided at acceptance
	always_comb begin
		acc_status = krt_pkg::STAT_OK;
		case (krt_pkg::op_t'(cmd.op))
			krt_pkg::OP_INSERT: begin
				if (cnt_q == krt_pkg::CW'(krt_pkg::CAPACITY))
					acc_status = krt_pkg::STAT_FULL;
				else if (krt_pkg::key_blank(folded))
					acc_status = krt_pkg::STAT_INVALID;
			end
			krt_pkg::OP_LIST_LOW: begin
				acc_status = krt_pkg::STAT_NOTFOUND;
			end
			default: begin
				if (cnt_q == '0)
					acc_status = krt_pkg::STAT_EMPTY;
			end
		endcase
	end

	// next state and RAM controls
	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_waddr = idx_q[krt_pkg::AW-1:0];
		ram_wrec  = cur_q;
		ram_raddr = idx_q[krt_pkg::AW-1:0];
		case (state_q)
			krt_pkg::ST_IDLE: begin
				if (cmd.valid) begin
					case (krt_pkg::op_t'(cmd.op))
						krt_pkg::OP_INSERT: begin
							if (acc_status != krt_pkg::STAT_OK)
								state_d = krt_pkg::ST_EMIT_ST;
							else if (cnt_q == '0)
								state_d = krt_pkg::ST_INS;
							else
								state_d = krt_pkg::ST_LK_RD;
						end
						krt_pkg::OP_SORT: begin
							if (cnt_q <= krt_pkg::CW'(1))
								state_d = krt_pkg::ST_EMIT_ST;
							else
								state_d = krt_pkg::ST_SO_START;
						end
						krt_pkg::OP_TOTAL: begin
							state_d = (cnt_q == '0) ? krt_pkg::ST_EMIT_ST : krt_pkg::ST_TO_RD;
						end
						krt_pkg::OP_LIST_ALL, krt_pkg::OP_LIST_LOW: begin
							state_d = (cnt_q == '0) ? krt_pkg::ST_EMIT_ST : krt_pkg::ST_LI_RD;
						end
						default: begin
							state_d = (cnt_q == '0) ? krt_pkg::ST_EMIT_ST : krt_pkg::ST_LK_RD;
						end
					endcase
				end
			end
			krt_pkg::ST_INS: begin
				if (price_q == '0) begin
					state_d = krt_pkg::ST_EMIT_ST;
				end else begin
					ram_we    = 1'b1;
					ram_waddr = cnt_q[krt_pkg::AW-1:0];
					ram_wrec  = '{key: key_q, price: price_q, stock: stock_q};
					state_d   = krt_pkg::ST_PROD;
				end
			end
			krt_pkg::ST_LK_RD: begin
				state_d = krt_pkg::ST_LK_CHK;
			end
			krt_pkg::ST_LK_CHK: begin
				if (lk_hit) begin
					case (op_q)
						krt_pkg::OP_INSERT:    state_d = krt_pkg::ST_EMIT_ST;
						krt_pkg::OP_SET_STOCK: state_d = krt_pkg::ST_SET;
						krt_pkg::OP_REMOVE:    state_d = krt_pkg::ST_SH_RD;
						default:               state_d = krt_pkg::ST_PROD;
					endcase
				end else if (idx_nxt == cnt_q) begin
					state_d = (op_q == krt_pkg::OP_INSERT) ? krt_pkg::ST_INS : krt_pkg::ST_EMIT_ST;
				end else begin
					state_d = krt_pkg::ST_LK_RD;
				end
			end
			krt_pkg::ST_SET: begin
				ram_we   = 1'b1;
				ram_wrec = '{key: rec_q.key, price: rec_q.price, stock: stock_q};
				state_d  = krt_pkg::ST_PROD;
			end
			krt_pkg::ST_SH_RD: begin
				ram_raddr = idx_nxt[krt_pkg::AW-1:0];
				state_d   = (idx_nxt < cnt_q) ? krt_pkg::ST_SH_WR : krt_pkg::ST_PROD;
			end
			krt_pkg::ST_SH_WR: begin
				ram_we   = 1'b1;
				ram_wrec = rd_rec;
				state_d  = krt_pkg::ST_SH_RD;
			end
			krt_pkg::ST_SO_START: begin
				ram_raddr = '0;
				state_d   = krt_pkg::ST_SO_LD;
			end
			krt_pkg::ST_SO_LD: begin
				state_d = krt_pkg::ST_SO_RD;
			end
			krt_pkg::ST_SO_RD: begin
				ram_raddr = idx_nxt[krt_pkg::AW-1:0];
				if (idx_q < lim_q) begin
					state_d = krt_pkg::ST_SO_CMP;
				end else begin
					ram_we  = 1'b1;
					state_d = (lim_q == krt_pkg::CW'(1)) ? krt_pkg::ST_EMIT_ST
						: krt_pkg::ST_SO_START;
				end
			end
			krt_pkg::ST_SO_CMP: begin
				ram_we   = 1'b1;
				ram_wrec = swap ? rd_rec : cur_q;
				state_d  = krt_pkg::ST_SO_RD;
			end
			krt_pkg::ST_TO_RD:  state_d = krt_pkg::ST_TO_LD;
			krt_pkg::ST_TO_LD:  state_d = krt_pkg::ST_TO_MUL;
			krt_pkg::ST_TO_MUL: state_d = krt_pkg::ST_TO_ACC;
			krt_pkg::ST_TO_ACC: begin
				state_d = (idx_nxt == cnt_q) ? krt_pkg::ST_EMIT_ST : krt_pkg::ST_TO_RD;
			end
			krt_pkg::ST_LI_RD: state_d = krt_pkg::ST_LI_LD;
			krt_pkg::ST_LI_LD: state_d = krt_pkg::ST_LI_CHK;
			krt_pkg::ST_LI_CHK: begin
				if (match)
					state_d = krt_pkg::ST_LI_PUT;
				else if (idx_nxt == cnt_q)
					state_d = krt_pkg::ST_LI_FIN;
				else
					state_d = krt_pkg::ST_LI_RD;
			end
			krt_pkg::ST_LI_PUT: begin
				if (!pend_q || out_free) begin
					if (kcnt_q + 1'b1 == krt_pkg::KW'(krt_pkg::MAX_OUT) || idx_nxt == cnt_q)
						state_d = krt_pkg::ST_LI_FIN;
					else
						state_d = krt_pkg::ST_LI_RD;
				end
			end
			krt_pkg::ST_LI_FIN, krt_pkg::ST_EMIT_REC, krt_pkg::ST_EMIT_ST: begin
				if (out_free)
					state_d = krt_pkg::ST_IDLE;
			end
			krt_pkg::ST_PROD: state_d = krt_pkg::ST_EMIT_REC;
			default: state_d = krt_pkg::ST_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= krt_pkg::ST_IDLE;
			cnt_q       <= '0;
			thr_q       <= krt_pkg::THR_RESET;
			pend_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
			kcnt_q      <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we)
				thr_q <= cfg_wdata;
			if (rsp.ready)
				rsp_valid_q <= 1'b0;
			case (state_q)
				krt_pkg::ST_IDLE: begin
					kcnt_q <= '0;
					pend_q <= 1'b0;
				end
				krt_pkg::ST_INS: begin
					if (price_q != '0)
						cnt_q <= cnt_q + 1'b1;
				end
				krt_pkg::ST_SH_RD: begin
					if (idx_nxt >= cnt_q)
						cnt_q <= cnt_q - 1'b1;
				end
				krt_pkg::ST_LI_PUT: begin
					if (!pend_q || out_free) begin
						pend_q <= 1'b1;
						kcnt_q <= kcnt_q + 1'b1;
						if (pend_q)
							rsp_valid_q <= 1'b1;
					end
				end
				krt_pkg::ST_LI_FIN, krt_pkg::ST_EMIT_REC, krt_pkg::ST_EMIT_ST: begin
					if (out_free)
						rsp_valid_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	// datapath and response payload
	always_ff @(posedge clk) begin
		prod_q <= rec_q.price * rec_q.stock;
		case (state_q)
			krt_pkg::ST_IDLE: begin
				if (cmd.valid) begin
					op_q     <= krt_pkg::op_t'(cmd.op);
					status_q <= acc_status;
					key_q    <= folded;
					price_q  <= cmd.price;
					stock_q  <= cmd.stock_count;
					desc_q   <= cmd.sort_descending;
					idx_q    <= '0;
					lim_q    <= cnt_q - 1'b1;
					sum_q    <= '0;
				end
			end
			krt_pkg::ST_INS: begin
				if (price_q == '0)
					status_q <= krt_pkg::STAT_INVALID;
				rec_q <= '{key: key_q, price: price_q, stock: stock_q};
			end
			krt_pkg::ST_LK_CHK: begin
				rec_q <= rd_rec;
				if (lk_hit)
					status_q <= (op_q == krt_pkg::OP_INSERT) ? krt_pkg::STAT_DUP
						: krt_pkg::STAT_OK;
				else if (idx_nxt == cnt_q)
					status_q <= krt_pkg::STAT_NOTFOUND;
				else
					idx_q <= idx_nxt;
			end
			krt_pkg::ST_SET: begin
				rec_q.stock <= stock_q;
			end
			krt_pkg::ST_SH_WR: begin
				idx_q <= idx_nxt;
			end
			krt_pkg::ST_SO_START: begin
				idx_q <= '0;
			end
			krt_pkg::ST_SO_LD: begin
				cur_q <= rd_rec;
			end
			krt_pkg::ST_SO_RD: begin
				if (idx_q >= lim_q)
					lim_q <= lim_q - 1'b1;
			end
			krt_pkg::ST_SO_CMP: begin
				if (!swap)
					cur_q <= rd_rec;
				idx_q <= idx_nxt;
			end
			krt_pkg::ST_TO_LD, krt_pkg::ST_LI_LD: begin
				rec_q <= rd_rec;
			end
			krt_pkg::ST_TO_ACC: begin
				sum_q <= (sum_add > {1'b0, krt_pkg::VALUE_MAX}) ? krt_pkg::VALUE_MAX
					: sum_add[krt_pkg::VALUE_W-1:0];
				idx_q <= idx_nxt;
			end
			krt_pkg::ST_LI_CHK: begin
				if (!match)
					idx_q <= idx_nxt;
			end
			krt_pkg::ST_LI_PUT: begin
				if (!pend_q || out_free) begin
					if (pend_q) begin
						rsp.status       <= krt_pkg::STAT_OK;
						rsp.out_key      <= pend_rec_q.key;
						rsp.out_price    <= pend_rec_q.price;
						rsp.out_stock    <= pend_rec_q.stock;
						rsp.out_value    <= krt_pkg::VALUE_W'(pend_prod_q);
						rsp.record_count <= cnt_q;
						rsp.last_result  <= 1'b0;
					end
					pend_rec_q  <= rec_q;
					pend_prod_q <= prod_q;
					idx_q       <= idx_nxt;
				end
			end
			krt_pkg::ST_LI_FIN: begin
				if (out_free) begin
					rsp.status       <= pend_q ? krt_pkg::STAT_OK : status_q;
					rsp.out_key      <= pend_q ? pend_rec_q.key : '0;
					rsp.out_price    <= pend_q ? pend_rec_q.price : '0;
					rsp.out_stock    <= pend_q ? pend_rec_q.stock : '0;
					rsp.out_value    <= pend_q ? krt_pkg::VALUE_W'(pend_prod_q) : '0;
					rsp.record_count <= cnt_q;
					rsp.last_result  <= 1'b1;
				end
			end
			krt_pkg::ST_EMIT_REC: begin
				if (out_free) begin
					rsp.status       <= krt_pkg::STAT_OK;
					rsp.out_key      <= rec_q.key;
					rsp.out_price    <= rec_q.price;
					rsp.out_stock    <= rec_q.stock;
					rsp.out_value    <= krt_pkg::VALUE_W'(prod_q);
					rsp.record_count <= cnt_q;
					rsp.last_result  <= 1'b1;
				end
			end
			krt_pkg::ST_EMIT_ST: begin
				if (out_free) begin
					rsp.status       <= status_q;
					rsp.out_key      <= '0;
					rsp.out_price    <= '0;
					rsp.out_stock    <= '0;
					rsp.out_value    <= sum_q;
					rsp.record_count <= cnt_q;
					rsp.last_result  <= 1'b1;
				end
			end
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	// record count never passes the table size
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= krt_pkg::CW'(krt_pkg::CAPACITY))
		else $error("record count beyond capacity");

	// a command is taken only when the sequencer is free, then it is busy
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.valid && cmd.ready |=> !cmd.ready)
		else $error("ready after acceptance");

	// count moves by at most one per cycle
	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != $past(cnt_q) |-> (cnt_q == $past(cnt_q) + 1'b1 ||
			cnt_q == $past(cnt_q) - 1'b1))
		else $error("record count jumped");

	// failed responses report no record
	a_fail_clear: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status != krt_pkg::STAT_OK |-> rsp.out_key == '0 &&
			rsp.out_value == '0 && rsp.last_result)
		else $error("failure word carries record data");
`endif

endmodule

[rtl/krt_ram.sv]
// ----------------------------------------------------------------------------
// krt_ram - generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module krt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		rd_data <= mem[rd_addr];
	end

endmodule

[bench/krt_tb_if.sv]
// ----------------------------------------------------------------------------
// krt_tb_if - bench side helpers for the keyed record table channels
// The channel interfaces themselves come with the block; this file only
// gathers the bench's word types so the top file stays focused on driving.
// ----------------------------------------------------------------------------
package krt_tb_pkg;
	import krt_pkg::*;

	// one command word as offered on cmd
	typedef struct {
		op_t         op;
		logic [63:0] key_code;
		logic [31:0] price;
		logic [15:0] stock_count;
		logic        sort_descending;
	} cmd_word_t;

	// one response word as seen on rsp
	typedef struct {
		stat_t       status;
		logic [63:0] out_key;
		logic [31:0] out_price;
		logic [15:0] out_stock;
		logic [53:0] out_value;
		logic [6:0]  record_count;
		logic        last_result;
	} rsp_word_t;
endpackage

[bench/keyed_record_table_core_test.sv]
// ----------------------------------------------------------------------------
// keyed_record_table_core_test - self-checking bench for the record table
// Drives directed and random commands through the table, mirrors the table
// contents in a scoreboard class and compares every response word in order,
// under several idling patterns and one long response hold-off.
// ----------------------------------------------------------------------------
module keyed_record_table_core_test;
	import krt_pkg::*;
	import krt_tb_pkg::*;

	// scoreboard: mirror of the table and queue of expected words
	class table_scoreboard;
		logic [63:0] keys[$];
		logic [31:0] prices[$];
		logic [15:0] stocks[$];
		logic [15:0] threshold;
		rsp_word_t   pending[$];
		int          mismatches;
		int          words_checked;

		function new();
			threshold = THR_RESET;
			mismatches = 0;
			words_checked = 0;
		endfunction

		function logic [63:0] fold(logic [63:0] raw);
			logic [63:0] r;
			logic [7:0] b;
			for (int i = 0; i < 8; i++) begin
				b = raw[8*i +: 8];
				if (b >= 8'h61 && b <= 8'h7A)
					b = b - 8'h20;
				r[8*i +: 8] = b;
			end
			return r;
		endfunction

		function bit blank(logic [63:0] k);
			logic [7:0] b;
			for (int i = 0; i < 8; i++) begin
				b = k[8*i +: 8];
				if (!(b == 8'h00 || b == 8'h20 || (b >= 8'h09 && b <= 8'h0D)))
					return 0;
			end
			return 1;
		endfunction

		function int position(logic [63:0] k);
			foreach (keys[i])
				if (keys[i] === k)
					return i;
			return -1;
		endfunction

		function void push(stat_t s, logic [63:0] k, logic [31:0] p, logic [15:0] st,
				logic [53:0] v, bit last);
			rsp_word_t w;
			w.status = s;
			w.out_key = k;
			w.out_price = p;
			w.out_stock = st;
			w.out_value = v;
			w.record_count = 7'(keys.size());
			w.last_result = last;
			pending.push_back(w);
		endfunction

		function void push_entry(int i, bit last);
			push(STAT_OK, keys[i], prices[i], stocks[i], 54'(prices[i]) * 54'(stocks[i]), last);
		endfunction

		function void fail_word(stat_t s);
			push(s, '0, '0, '0, '0, 1'b1);
		endfunction

		// note an accepted command and queue what it must answer
		function void note_command(cmd_word_t c);
			logic [63:0] k;
			int idx, n, cnt;
			logic [63:0] tk;
			logic [31:0] tp;
			logic [15:0] ts;
			logic [54:0] sum;
			bit sw;
			k = fold(c.key_code);
			n = keys.size();
			if (c.op == OP_INSERT) begin
				if (n >= CAPACITY) fail_word(STAT_FULL);
				else if (blank(k)) fail_word(STAT_INVALID);
				else if (position(k) >= 0) fail_word(STAT_DUP);
				else if (c.price == 0) fail_word(STAT_INVALID);
				else begin
					keys.push_back(k);
					prices.push_back(c.price);
					stocks.push_back(c.stock_count);
					push_entry(n, 1'b1);
				end
				return;
			end
			if (c.op == OP_LIST_LOW) begin
				cnt = 0;
				for (int i = 0; i < n && cnt < MAX_OUT; i++)
					if (stocks[i] < threshold) begin
						push_entry(i, 1'b0);
						cnt++;
					end
				if (cnt == 0) fail_word(STAT_NOTFOUND);
				else pending[pending.size()-1].last_result = 1'b1;
				return;
			end
			if (n == 0) begin
				fail_word(STAT_EMPTY);
				return;
			end
			case (c.op)
				OP_FIND, OP_SET_STOCK: begin
					idx = position(k);
					if (idx < 0) fail_word(STAT_NOTFOUND);
					else begin
						if (c.op == OP_SET_STOCK)
							stocks[idx] = c.stock_count;
						push_entry(idx, 1'b1);
					end
				end
				OP_REMOVE: begin
					idx = position(k);
					if (idx < 0) fail_word(STAT_NOTFOUND);
					else begin
						tk = keys[idx];
						tp = prices[idx];
						ts = stocks[idx];
						keys.delete(idx);
						prices.delete(idx);
						stocks.delete(idx);
						push(STAT_OK, tk, tp, ts, 54'(tp) * 54'(ts), 1'b1);
					end
				end
				OP_SORT: begin
					for (int i = 0; i + 1 < n; i++)
						for (int j = 0; j + 1 < n - i; j++) begin
							sw = c.sort_descending ? (stocks[j] < stocks[j+1])
								: (stocks[j] > stocks[j+1]);
							if (sw) begin
								tk = keys[j]; keys[j] = keys[j+1]; keys[j+1] = tk;
								tp = prices[j]; prices[j] = prices[j+1]; prices[j+1] = tp;
								ts = stocks[j]; stocks[j] = stocks[j+1]; stocks[j+1] = ts;
							end
						end
					push(STAT_OK, '0, '0, '0, '0, 1'b1);
				end
				OP_TOTAL: begin
					sum = '0;
					for (int i = 0; i < n; i++) begin
						sum = sum + prices[i] * stocks[i];
						if (sum > VALUE_MAX)
							sum = VALUE_MAX;
					end
					push(STAT_OK, '0, '0, '0, sum[53:0], 1'b1);
				end
				default: begin
					for (int i = 0; i < n && i < MAX_OUT; i++)
						push_entry(i, (i == n - 1) || (i == MAX_OUT - 1));
				end
			endcase
		endfunction

		// compare one response word with the oldest expectation
		function void check_word(rsp_word_t a);
			rsp_word_t e;
			words_checked++;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word: status %0d key %h", a.status, a.out_key);
				return;
			end
			e = pending.pop_front();
			if (a.status !== e.status || a.out_key !== e.out_key ||
					a.out_price !== e.out_price || a.out_stock !== e.out_stock ||
					a.out_value !== e.out_value || a.record_count !== e.record_count ||
					a.last_result !== e.last_result) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("mismatch: exp st %0d key %h pr %0d sk %0d val %0d cnt %0d last %0d",
						e.status, e.out_key, e.out_price, e.out_stock, e.out_value,
						e.record_count, e.last_result);
					$display("          got st %0d key %h pr %0d sk %0d val %0d cnt %0d last %0d",
						a.status, a.out_key, a.out_price, a.out_stock, a.out_value,
						a.record_count, a.last_result);
				end
			end
		endfunction
	endclass

	localparam int LIMIT = 5000000;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [15:0] cfg_wdata;
	int          cycle;
	int          send_idle_pct;
	int          stall_pct;
	int          hold_off;
	int          commands_sent;
	logic [63:0] used_keys[$];
	table_scoreboard board;

	krt_cmd_if cmd ();
	krt_rsp_if rsp ();

	keyed_record_table_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// cycle count and timeout
	always @(posedge clk) begin
		cycle <= cycle + 1;
		if (cycle > LIMIT) begin
			$display("timeout after %0d cycles", cycle);
			$display("keyed_record_table_core_test NOT OK");
			$finish;
		end
	end

	// response side: random stall, long hold-off, sample at rising edge
	always @(negedge clk) begin
		if (hold_off > 0) begin
			rsp.ready <= 1'b0;
			hold_off <= hold_off - 1;
		end else
			rsp.ready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		rsp_word_t w;
		if (arst_n && rsp.valid && rsp.ready) begin
			w.status = stat_t'(rsp.status);
			w.out_key = rsp.out_key;
			w.out_price = rsp.out_price;
			w.out_stock = rsp.out_stock;
			w.out_value = rsp.out_value;
			w.record_count = rsp.record_count;
			w.last_result = rsp.last_result;
			board.check_word(w);
		end
	end

	// offer one command word and wait for it to be taken; valid stays up
	// after acceptance until the next command or idle cycle replaces it
	task automatic send_command(cmd_word_t c);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd.valid <= 1'b0;
			@(negedge clk);
		end
		cmd.valid <= 1'b1;
		cmd.op <= c.op;
		cmd.key_code <= c.key_code;
		cmd.price <= c.price;
		cmd.stock_count <= c.stock_count;
		cmd.sort_descending <= c.sort_descending;
		do
			@(posedge clk);
		while (!cmd.ready);
		board.note_command(c);
		commands_sent++;
		@(negedge clk);
	endtask

	task automatic send(op_t op, logic [63:0] k, logic [31:0] p, logic [15:0] s, logic d);
		cmd_word_t c;
		c.op = op;
		c.key_code = k;
		c.price = p;
		c.stock_count = s;
		c.sort_descending = d;
		send_command(c);
	endtask

	// wait until all expected words arrived, plus settling time
	task automatic drain();
		cmd.valid <= 1'b0;
		while (board.pending.size() != 0)
			@(negedge clk);
		repeat (300) @(negedge clk);
	endtask

	task automatic write_threshold(logic [15:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		board.threshold = v;
	endtask

	// random key: either a fresh mixed-case word or one already used
	function automatic logic [63:0] pick_key();
		logic [63:0] k;
		if (used_keys.size() != 0 && $urandom_range(99) < 55) begin
			k = used_keys[$urandom_range(used_keys.size() - 1)];
			if ($urandom_range(1)) k ^= 64'h20 << (8 * $urandom_range(7));
			return k;
		end
		for (int i = 0; i < 8; i++)
			k[8*i +: 8] = ($urandom_range(3) == 0) ? 8'($urandom)
				: 8'($urandom_range(1) ? $urandom_range(8'h41, 8'h5A)
				: $urandom_range(8'h61, 8'h7A));
		if (used_keys.size() < 200) used_keys.push_back(k);
		return k;
	endfunction

	task automatic random_phase(int count, int idle, int stall);
		logic [31:0] p;
		logic [15:0] s;
		int r;
		send_idle_pct = idle;
		stall_pct = stall;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(99);
			p = ($urandom_range(9) == 0) ? 32'($urandom_range(1) ? 0 : 32'hFFFF_FFFF) : $urandom;
			s = ($urandom_range(9) == 0) ? 16'hFFFF : 16'($urandom_range(12));
			if (r < 40) send(OP_INSERT, pick_key(), p, s, 1'b0);
			else if (r < 50) send(OP_FIND, pick_key(), p, s, 1'b0);
			else if (r < 60) send(OP_SET_STOCK, pick_key(), p, 16'($urandom), 1'b0);
			else if (r < 72) send(OP_REMOVE, pick_key(), p, s, 1'b0);
			else if (r < 78) send(OP_SORT, 64'($urandom), p, s, 1'($urandom));
			else if (r < 84) send(OP_TOTAL, pick_key(), p, s, 1'b0);
			else if (r < 92) send(OP_LIST_ALL, pick_key(), p, s, 1'b0);
			else send(OP_LIST_LOW, pick_key(), p, s, 1'b0);
		end
	endtask

	initial begin
		board = new();
		cycle = 0;
		hold_off = 0;
		commands_sent = 0;
		send_idle_pct = 0;
		stall_pct = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		cmd.valid = 1'b0;
		cmd.op = OP_INSERT;
		cmd.key_code = '0;
		cmd.price = '0;
		cmd.stock_count = '0;
		cmd.sort_descending = 1'b0;
		rsp.ready = 1'b0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: empty table, insert checks, every command
		send(OP_FIND, 64'h41, 32'd1, 16'd1, 1'b0);
		send(OP_LIST_ALL, '0, '0, '0, 1'b0);
		send(OP_LIST_LOW, '0, '0, '0, 1'b0);
		send(OP_TOTAL, '0, '0, '0, 1'b0);
		send(OP_SORT, '0, '0, '0, 1'b1);
		send(OP_REMOVE, 64'h41, '0, '0, 1'b0);
		send(OP_INSERT, 64'h0, 32'd5, 16'd5, 1'b0);
		send(OP_INSERT, 64'h0D0C_0B0A_0920_0000, 32'd5, 16'd5, 1'b0);
		send(OP_INSERT, 64'h6162_6364, '0, 16'd5, 1'b0);
		send(OP_INSERT, 64'h6162_6364, 32'hFFFF_FFFF, 16'hFFFF, 1'b0);
		send(OP_INSERT, 64'h4142_4344, 32'd7, 16'd3, 1'b0);
		send(OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 32'd1, '0, 1'b0);
		send(OP_INSERT, 64'h7A7A_7A7A_7A7A_7A7A, 32'hFFFF_FFFF, 16'hFFFF, 1'b0);
		send(OP_INSERT, 64'h31, 32'd100, 16'd2, 1'b0);
		send(OP_FIND, 64'h6162_6364, '0, '0, 1'b0);
		send(OP_FIND, 64'h99, '0, '0, 1'b0);
		send(OP_SET_STOCK, 64'h31, '0, 16'd9, 1'b0);
		send(OP_SET_STOCK, 64'h32, '0, 16'd9, 1'b0);
		send(OP_TOTAL, '0, '0, '0, 1'b0);
		send(OP_SORT, '0, '0, '0, 1'b0);
		send(OP_LIST_ALL, '0, '0, '0, 1'b0);
		send(OP_SORT, '0, '0, '0, 1'b1);
		send(OP_LIST_LOW, '0, '0, '0, 1'b0);
		send(OP_REMOVE, 64'h6162_6364, '0, '0, 1'b0);
		send(OP_REMOVE, 64'h77, '0, '0, 1'b0);

		// fill to capacity with long stall, then full-table checks
		write_threshold(16'hFFFF);
		hold_off = 400;
		for (int i = 0; i < 66; i++)
			send(OP_INSERT, 64'h4B00_0000 | 64'(i), 32'hFFFF_FFFF - 32'(i),
				16'hFFFF - 16'(i), 1'b0);
		send(OP_TOTAL, '0, '0, '0, 1'b0);
		send(OP_LIST_ALL, '0, '0, '0, 1'b0);
		send(OP_LIST_LOW, '0, '0, '0, 1'b0);
		send(OP_SORT, '0, '0, '0, 1'b0);
		for (int i = 0; i < 66; i++)
			send(OP_REMOVE, 64'h4B00_0000 | 64'(i), '0, '0, 1'b0);

		// random phases under varying idling and thresholds
		write_threshold(16'd0);
		random_phase(18, 0, 0);
		write_threshold(16'd7);
		random_phase(18, 67, 0);
		write_threshold(16'd3);
		random_phase(18, 0, 67);
		write_threshold(16'd10);
		random_phase(18, 37, 37);
		send_idle_pct = 0;
		stall_pct = 0;
		drain();

		$display("%0d commands sent, %0d response words checked", commands_sent,
			board.words_checked);
		if (board.mismatches == 0 && board.pending.size() == 0)
			$display("keyed_record_table_core_test OK");
		else
			$display("keyed_record_table_core_test NOT OK");
		$finish;
	end
endmodule

[keyed_record_table_core.f]
rtl/krt_pkg.sv
rtl/krt_if.sv
rtl/krt_ram.sv
rtl/keyed_record_table_core.sv
bench/krt_tb_if.sv
bench/keyed_record_table_core_test.sv
